FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros, sampled on clk, off during rst_n low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TRQ_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define TRQ_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: rtl/trq_pkg.sv
// ----------------------------------------------------------------------------
// trq_pkg
// command and status codes and beat layouts of the thread run queue
// ----------------------------------------------------------------------------
package trq_pkg;

    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int ID_FIELD_W  = 16;
    localparam int HDL_FIELD_W = 16;
    localparam int COUNT_W     = 5;

    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]       command;
        logic [ID_FIELD_W-1:0]  thread_id;
        logic [HDL_FIELD_W-1:0] context_handle;
    } cmd_beat_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [ID_FIELD_W-1:0]  out_thread_id;
        logic [HDL_FIELD_W-1:0] out_handle;
        logic [COUNT_W-1:0]     entry_count;
    } rsp_beat_t;

endpackage

FILE: rtl/trq_if.sv
// ----------------------------------------------------------------------------
// trq_if
// valid/ready channels for command beats and response beats
// ----------------------------------------------------------------------------
interface trq_cmd_if;
    logic                valid;
    logic                ready;
    trq_pkg::cmd_beat_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface trq_rsp_if;
    logic                valid;
    logic                ready;
    trq_pkg::rsp_beat_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/thread_run_queue_core.sv
// ----------------------------------------------------------------------------
// thread_run_queue_core
// ordered run queue of thread entries: append, pop head, remove by id
// ----------------------------------------------------------------------------
// One command is worked at a time; cmd.ready is high while the sequencer is
// idle, also while a response still waits in the output register. Entries
// sit in a circular slot memory with a single read port with registered
// read data, and that port sets the timing: append writes its slot before
// its response, pop reads the head slot first, and remove reads one slot per
// cycle from the head until the id matches, then moves each later entry down
// one slot per cycle before its response.
`include "assert_macros.svh"

module thread_run_queue_core #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    trq_cmd_if.sink         cmd,
    trq_rsp_if.source       rsp
);

    localparam int AW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int IdW   = (ID_BITS < trq_pkg::ID_FIELD_W) ? ID_BITS : trq_pkg::ID_FIELD_W;
    localparam int HdW   = (HANDLE_BITS < trq_pkg::HDL_FIELD_W) ?
                           HANDLE_BITS : trq_pkg::HDL_FIELD_W;
    localparam int SlotW = IdW + HdW;
    localparam int CntW  = (CW < trq_pkg::COUNT_W) ? CW : trq_pkg::COUNT_W;

    localparam logic [CW-1:0] DepthC = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] OneC   = CW'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP_RD,
        ST_SEARCH,
        ST_SHIFT,
        ST_DONE
    } state_t;

    state_t                   state_reg, state_next;
    logic [AW-1:0]            head_reg, head_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            rd_pos_reg, rd_pos_next;
    logic [IdW-1:0]           key_reg, key_next;
    logic [trq_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [IdW-1:0]           res_id_reg, res_id_next;
    logic [HdW-1:0]           res_handle_reg, res_handle_next;
    logic                     rsp_valid_reg, rsp_valid_next;
    trq_pkg::rsp_beat_t       rsp_beat_reg, rsp_beat_next;

    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [SlotW-1:0]         wr_data;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic [SlotW-1:0]         rd_data;
    logic [IdW-1:0]           rd_id;
    logic [HdW-1:0]           rd_handle;
    logic [CW-1:0]            pos_inc;

    // logical position to slot address
    function automatic logic [AW-1:0] slot_addr(input logic [AW-1:0] head,
                                                input logic [CW-1:0] pos);
        logic [AW:0] sum;
        sum = (AW+1)'(head) + (AW+1)'(pos);
        if (sum >= (AW+1)'(QUEUE_DEPTH))
        begin
            sum = sum - (AW+1)'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    trq_slot_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (SlotW)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_id     = rd_data[SlotW-1:HdW];
    assign rd_handle = rd_data[HdW-1:0];
    assign pos_inc   = rd_pos_reg + OneC;

    assign cmd.ready   = (state_reg == ST_IDLE);
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_beat_reg;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        rd_pos_next     = rd_pos_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_handle_next = res_handle_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_beat_next   = rsp_beat_reg;
        wr_en           = 1'b0;
        wr_addr         = slot_addr(head_reg, count_reg);
        wr_data         = {cmd.payload.thread_id[IdW-1:0],
                           cmd.payload.context_handle[HdW-1:0]};
        rd_en           = 1'b0;
        rd_addr         = head_reg;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    key_next        = cmd.payload.thread_id[IdW-1:0];
                    res_status_next = trq_pkg::STATUS_OK;
                    res_id_next     = '0;
                    res_handle_next = '0;
                    state_next      = ST_DONE;
                    case (cmd.payload.command)
                        trq_pkg::CMD_APPEND:
                        begin
                            if (count_reg == DepthC)
                            begin
                                res_status_next = trq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + OneC;
                            end
                        end
                        trq_pkg::CMD_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = trq_pkg::STATUS_MISS;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                state_next = ST_POP_RD;
                            end
                        end
                        trq_pkg::CMD_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = trq_pkg::STATUS_MISS;
                            end
                            else
                            begin
                                rd_en       = 1'b1;
                                rd_pos_next = '0;
                                state_next  = ST_SEARCH;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_POP_RD:
            begin
                res_id_next     = rd_id;
                res_handle_next = rd_handle;
                head_next       = slot_addr(head_reg, OneC);
                count_next      = count_reg - OneC;
                state_next      = ST_DONE;
            end

            ST_SEARCH:
            begin
                // read ahead one slot so a hit can start the shift at once
                rd_en   = 1'b1;
                rd_addr = slot_addr(head_reg, pos_inc);
                if (rd_id == key_reg)
                begin
                    res_id_next     = rd_id;
                    res_handle_next = rd_handle;
                    if (pos_inc == count_reg)
                    begin
                        count_next = count_reg - OneC;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        rd_pos_next = pos_inc;
                        state_next  = ST_SHIFT;
                    end
                end
                else if (pos_inc == count_reg)
                begin
                    res_status_next = trq_pkg::STATUS_MISS;
                    state_next      = ST_DONE;
                end
                else
                begin
                    rd_pos_next = pos_inc;
                end
            end

            ST_SHIFT:
            begin
                // move slot rd_pos down by one, fetch the next
                wr_en   = 1'b1;
                wr_addr = slot_addr(head_reg, rd_pos_reg - OneC);
                wr_data = rd_data;
                rd_en   = 1'b1;
                rd_addr = slot_addr(head_reg, pos_inc);
                if (pos_inc == count_reg)
                begin
                    count_next = count_reg - OneC;
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_pos_next = pos_inc;
                end
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next                       = 1'b1;
                    rsp_beat_next                        = '0;
                    rsp_beat_next.status                 = res_status_reg;
                    rsp_beat_next.out_thread_id[IdW-1:0] = res_id_reg;
                    rsp_beat_next.out_handle[HdW-1:0]    = res_handle_reg;
                    rsp_beat_next.entry_count[CntW-1:0]  = count_reg[CntW-1:0];
                    state_next                           = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            rd_pos_reg     <= '0;
            key_reg        <= '0;
            res_status_reg <= trq_pkg::STATUS_OK;
            res_id_reg     <= '0;
            res_handle_reg <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_beat_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            rd_pos_reg     <= rd_pos_next;
            key_reg        <= key_next;
            res_status_reg <= res_status_next;
            res_id_reg     <= res_id_next;
            res_handle_reg <= res_handle_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_beat_reg   <= rsp_beat_next;
        end
    end

    `TRQ_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= DepthC, "entry count above queue depth")
    `TRQ_ASSERT_IMP(a_search_pos, state_reg == ST_SEARCH, rd_pos_reg < count_reg, "search past tail")
    `TRQ_ASSERT_IMP(a_shift_pos, state_reg == ST_SHIFT, (rd_pos_reg != '0) && (rd_pos_reg < count_reg), "shift position out of range")
    `TRQ_ASSERT_NXT(a_cmd_leaves_idle, cmd.valid && cmd.ready, state_reg != ST_IDLE, "accepted beat not worked")
    `TRQ_ASSERT_NXT(a_count_step, state_reg != ST_DONE, (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + OneC) || (count_reg == $past(count_reg) - OneC), "count moved by more than one")

endmodule

FILE: rtl/trq_slot_ram.sv
// ----------------------------------------------------------------------------
// trq_slot_ram
// slot storage, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module trq_slot_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: verif/thread_run_queue_core_tb.sv
// ----------------------------------------------------------------------------
// thread_run_queue_core_tb
// Self-checking bench for the thread run queue. A directed table covers the
// empty, full, duplicate-id, no-match and unused-command cases and the field
// extremes. A random mix of append, pop, remove and unused beats follows,
// alternating fill-heavy and drain-heavy runs, with ids drawn half the time
// from a small pool and for removes mostly from the queued entries. A shadow
// queue or the table gives each expected response, compared field by field.
// Idling on the command and response sides changes from phase to phase.
// ----------------------------------------------------------------------------
module thread_run_queue_core_tb;

    localparam int QDEPTH       = 16;
    localparam int RANDOM_ITEMS = 1700;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = QDEPTH + 10;

    localparam int ID_W  = trq_pkg::ID_FIELD_W;
    localparam int HDL_W = trq_pkg::HDL_FIELD_W;
    localparam int CNT_W = trq_pkg::COUNT_W;

    localparam logic [trq_pkg::CMD_W-1:0] CMD_RESERVED = 2'd3;

    typedef struct {
        logic [ID_W-1:0]  id;
        logic [HDL_W-1:0] handle;
    } thread_entry_t;

    typedef struct {
        logic [trq_pkg::CMD_W-1:0] command;
        logic [ID_W-1:0]           id;
        logic [HDL_W-1:0]          handle;
        int                        times;
        bit                        known;
        trq_pkg::rsp_beat_t        want;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n;

    trq_cmd_if cmd_ch ();
    trq_rsp_if rsp_ch ();

    thread_run_queue_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    thread_entry_t      shadow_queue[$];
    trq_pkg::rsp_beat_t pending_responses[$];
    int                 mismatch_count = 0;
    int                 cycle_count    = 0;
    int                 cmd_idle_pct   = 0;
    int                 rsp_stall_pct  = 0;

    directed_row_t directed_rows [0:13] = '{
        '{trq_pkg::CMD_POP,    16'h0000, 16'h0000, 1,  1'b1,
          '{trq_pkg::STATUS_MISS, 16'h0, 16'h0, 5'd0}},
        '{trq_pkg::CMD_REMOVE, 16'h0000, 16'h0000, 1,  1'b1,
          '{trq_pkg::STATUS_MISS, 16'h0, 16'h0, 5'd0}},
        '{CMD_RESERVED,        16'hFFFF, 16'hFFFF, 1,  1'b1,
          '{trq_pkg::STATUS_OK,   16'h0, 16'h0, 5'd0}},
        '{trq_pkg::CMD_APPEND, 16'hFFFF, 16'h0000, 1,  1'b1,
          '{trq_pkg::STATUS_OK,   16'h0, 16'h0, 5'd1}},
        '{trq_pkg::CMD_APPEND, 16'h0000, 16'hFFFF, 1,  1'b1,
          '{trq_pkg::STATUS_OK,   16'h0, 16'h0, 5'd2}},
        '{trq_pkg::CMD_APPEND, 16'h1234, 16'hAAAA, 1,  1'b0,
          '{trq_pkg::STATUS_OK,   16'h0, 16'h0, 5'd0}},
        '{trq_pkg::CMD_APPEND, 16'h1234, 16'h5555, 1,  1'b0,
          '{trq_pkg::STATUS_OK,   16'h0, 16'h0, 5'd0}},
        '{trq_pkg::CMD_REMOVE, 16'h1234, 16'h0000, 1,  1'b0,
          '{trq_pkg::STATUS_OK,   16'h0, 16'h0, 5'd0}},
        '{trq_pkg::CMD_REMOVE, 16'h9999, 16'h0000, 1,  1'b1,
          '{trq_pkg::STATUS_MISS, 16'h0, 16'h0, 5'd3}},
        '{trq_pkg::CMD_POP,    16'h0000, 16'h0000, 1,  1'b0,
          '{trq_pkg::STATUS_OK,   16'h0, 16'h0, 5'd0}},
        '{trq_pkg::CMD_APPEND, 16'h8000, 16'h7FFF, 14, 1'b0,
          '{trq_pkg::STATUS_OK,   16'h0, 16'h0, 5'd0}},
        '{trq_pkg::CMD_APPEND, 16'h4321, 16'h0001, 1,  1'b1,
          '{trq_pkg::STATUS_FULL, 16'h0, 16'h0, 5'd16}},
        '{trq_pkg::CMD_REMOVE, 16'h800D, 16'h0000, 1,  1'b0,
          '{trq_pkg::STATUS_OK,   16'h0, 16'h0, 5'd0}},
        '{trq_pkg::CMD_REMOVE, 16'h0000, 16'h0000, 1,  1'b0,
          '{trq_pkg::STATUS_OK,   16'h0, 16'h0, 5'd0}}
    };

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic trq_pkg::rsp_beat_t next_queue_response(trq_pkg::cmd_beat_t beat);
        trq_pkg::rsp_beat_t r;
        int                 hit;
        r        = '0;
        r.status = trq_pkg::STATUS_OK;
        hit      = -1;
        case (beat.command)
            trq_pkg::CMD_APPEND:
            begin
                if (shadow_queue.size() >= QDEPTH)
                    r.status = trq_pkg::STATUS_FULL;
                else
                    shadow_queue.push_back('{beat.thread_id, beat.context_handle});
            end
            trq_pkg::CMD_POP:
            begin
                if (shadow_queue.size() == 0)
                    r.status = trq_pkg::STATUS_MISS;
                else
                begin
                    r.out_thread_id = shadow_queue[0].id;
                    r.out_handle    = shadow_queue[0].handle;
                    void'(shadow_queue.pop_front());
                end
            end
            trq_pkg::CMD_REMOVE:
            begin
                foreach (shadow_queue[i])
                    if (hit < 0 && shadow_queue[i].id == beat.thread_id)
                        hit = i;
                if (hit < 0)
                    r.status = trq_pkg::STATUS_MISS;
                else
                begin
                    r.out_thread_id = shadow_queue[hit].id;
                    r.out_handle    = shadow_queue[hit].handle;
                    shadow_queue.delete(hit);
                end
            end
            default: ;
        endcase
        r.entry_count = CNT_W'(shadow_queue.size());
        return r;
    endfunction

    function automatic trq_pkg::cmd_beat_t random_command(int append_pct);
        trq_pkg::cmd_beat_t beat;
        int                 sel;
        sel                 = $urandom_range(99);
        beat.context_handle = HDL_W'($urandom_range(16'hFFFF));
        if ($urandom_range(1) == 1)
            beat.thread_id = ID_W'($urandom_range(7));
        else
            beat.thread_id = ID_W'($urandom_range(16'hFFFF));
        if (sel < 3)
            beat.command = CMD_RESERVED;
        else if (sel < append_pct)
            beat.command = trq_pkg::CMD_APPEND;
        else if (sel < append_pct + (100 - append_pct) / 2)
            beat.command = trq_pkg::CMD_POP;
        else
        begin
            beat.command = trq_pkg::CMD_REMOVE;
            if (shadow_queue.size() != 0 && $urandom_range(3) != 0)
                beat.thread_id = shadow_queue[$urandom_range(shadow_queue.size() - 1)].id;
        end
        return beat;
    endfunction

    // optional gap before a beat, then hold valid until the handshake
    task automatic issue_beat(trq_pkg::cmd_beat_t beat, bit known, trq_pkg::rsp_beat_t typed);
        trq_pkg::rsp_beat_t predicted;
        if ($urandom_range(99) < cmd_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < cmd_idle_pct);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.payload <= beat;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        predicted = next_queue_response(beat);
        pending_responses.push_back(known ? typed : predicted);
    endtask

    function automatic void compare_field(string label, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h got %0h", $time, label, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin : rsp_side
        trq_pkg::rsp_beat_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_responses.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none got %0h", $time, rsp_ch.payload);
                mismatch_count++;
            end
            else
            begin
                want = pending_responses.pop_front();
                compare_field("status", 16'(want.status), 16'(rsp_ch.payload.status));
                compare_field("out_thread_id", want.out_thread_id,
                              rsp_ch.payload.out_thread_id);
                compare_field("out_handle", want.out_handle, rsp_ch.payload.out_handle);
                compare_field("entry_count", 16'(want.entry_count),
                              16'(rsp_ch.payload.entry_count));
            end
        end
        rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL thread_run_queue_core");
            $finish;
        end
    end

    initial
    begin : stimulus
        trq_pkg::cmd_beat_t beat;
        int                 counted;
        int                 phase;
        rst_n          <= 1'b0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.payload <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            for (int k = 0; k < directed_rows[r].times; k++)
            begin
                beat.command        = directed_rows[r].command;
                beat.thread_id      = ID_W'(directed_rows[r].id + k);
                beat.context_handle = directed_rows[r].handle;
                issue_beat(beat, directed_rows[r].known, directed_rows[r].want);
            end

        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            phase = counted * 4 / RANDOM_ITEMS;
            case (phase)
                0:       begin cmd_idle_pct = 0;  rsp_stall_pct = 0;  end
                1:       begin cmd_idle_pct = 53; rsp_stall_pct = 0;  end
                2:       begin cmd_idle_pct = 0;  rsp_stall_pct = 53; end
                default: begin cmd_idle_pct = 28; rsp_stall_pct = 28; end
            endcase
            beat = random_command(((counted / 40) % 2 == 0) ? 70 : 25);
            issue_beat(beat, 1'b0, '0);
            if (beat.command != CMD_RESERVED)
                counted++;
        end
        cmd_ch.valid <= 1'b0;

        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS thread_run_queue_core");
        else
            $display("FAIL thread_run_queue_core");
        $finish;
    end

endmodule
